// ----- src/synth_voice_allocator_macros.svh -----
// Assertion macros shared by the voice allocator RTL.
`ifndef SYNTH_VOICE_ALLOCATOR_MACROS_SVH
`define SYNTH_VOICE_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
// Check that cond holds whenever trig holds, same cycle.
`define SVA_ASSERT_IMP(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");
// Check that cond holds in the cycle after trig.
`define SVA_ASSERT_NXT(lbl, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");
`else
`define SVA_ASSERT_IMP(lbl, trig, cond)
`define SVA_ASSERT_NXT(lbl, trig, cond)
`endif
`endif

// ----- src/sva_pkg.sv -----
// Shared constants and types for the voice allocator.
package sva_pkg;
    localparam int VOICES      = 3;
    localparam int STACK_DEPTH = 16;
    localparam int VIDX_W      = 2;
    localparam int SIDX_W      = $clog2(STACK_DEPTH);
    localparam int SCNT_W      = $clog2(STACK_DEPTH + 1);
    localparam int NOTE_W      = 7;
    localparam int STAMP_W     = 32;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] FUNC_ON  = 2'd0;
    localparam logic [1:0] FUNC_OFF = 2'd1;
    localparam logic [1:0] FUNC_ALL = 2'd2;

    localparam logic [2:0] OP_POLY_ON  = 3'd0;
    localparam logic [2:0] OP_MONO_ON  = 3'd1;
    localparam logic [2:0] OP_POLY_OFF = 3'd2;
    localparam logic [2:0] OP_MONO_OFF = 3'd3;
    localparam logic [2:0] OP_ALL_OFF  = 3'd4;

    typedef struct packed {
        logic [2:0]        op;
        logic [NOTE_W-1:0] note;
        logic [NOTE_W-1:0] vel;
    } cmd_t;
endpackage

// ----- src/sva_front.sv -----
// Front end: takes note events and the mode register, classifies events into commands.
module sva_front
    import sva_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [1:0]        func,
    input  logic [NOTE_W-1:0] note,
    input  logic [NOTE_W-1:0] velocity,
    input  logic              cfg_valid,
    input  logic              cfg_data,
    input  logic              fifo_full,
    output logic              busy,
    output logic              cfg_ready,
    output logic              push,
    output cmd_t              cmd
);
    logic poly_mode_reg, poly_mode_next;
    logic [2:0] op;
    logic known;

    assign busy      = fifo_full;
    assign cfg_ready = 1'b1;
    assign poly_mode_next = (cfg_valid && cfg_ready) ? cfg_data : poly_mode_reg;

    always_comb
    begin
        known = 1'b1;
        case (func)
            FUNC_ON:  op = poly_mode_reg ? OP_POLY_ON : OP_MONO_ON;
            FUNC_OFF: op = poly_mode_reg ? OP_POLY_OFF : OP_MONO_OFF;
            FUNC_ALL: op = OP_ALL_OFF;
            default:
            begin
                // drop unknown event kinds
                op    = OP_ALL_OFF;
                known = 1'b0;
            end
        endcase
    end

    assign push     = start && !busy && known;
    assign cmd.op   = op;
    assign cmd.note = note;
    assign cmd.vel  = velocity;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            poly_mode_reg <= 1'b0;
        else
            poly_mode_reg <= poly_mode_next;
    end
endmodule

// ----- src/sva_fifo.sv -----
// Short command queue between front and back end.
module sva_fifo
    import sva_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic full,
    output logic empty
);
    `include "synth_voice_allocator_macros.svh"

    cmd_t                  slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [FIFO_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  do_push, do_pop;

    assign full    = (cnt_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = slot_reg[rp_reg];

    always_comb
    begin
        wp_next  = do_push ? FIFO_PTR_W'(wp_reg + 1'b1) : wp_reg;
        rp_next  = do_pop ? FIFO_PTR_W'(rp_reg + 1'b1) : rp_reg;
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
            cnt_next = FIFO_CNT_W'(cnt_reg + 1'b1);
        else if (do_pop && !do_push)
            cnt_next = FIFO_CNT_W'(cnt_reg - 1'b1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wp_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    `SVA_ASSERT_IMP(a_cnt_range, 1'b1, cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
    `SVA_ASSERT_IMP(a_full_not_empty, 1'b1, !(full && empty))
    `SVA_ASSERT_NXT(a_push_grows, do_push && !do_pop, !empty)
endmodule

// ----- src/sva_back.sv -----
// Back end: voice state, note stack and result sequencing.
module sva_back
    import sva_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fifo_empty,
    input  cmd_t              fifo_cmd,
    output logic              pop,
    output logic              result_valid,
    output logic [VIDX_W-1:0] voice,
    output logic [NOTE_W-1:0] voice_note,
    output logic [NOTE_W-1:0] voice_velocity,
    output logic              gate,
    output logic              restart,
    output logic              last
);
    `include "synth_voice_allocator_macros.svh"

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_PSCAN    = 4'd1;
    localparam logic [3:0] S_PON      = 4'd2;
    localparam logic [3:0] S_POFF     = 4'd3;
    localparam logic [3:0] S_RM_RD    = 4'd4;
    localparam logic [3:0] S_RM_CMP   = 4'd5;
    localparam logic [3:0] S_SH_RD    = 4'd6;
    localparam logic [3:0] S_SH_WR    = 4'd7;
    localparam logic [3:0] S_PUSH     = 4'd8;
    localparam logic [3:0] S_TOP_RD   = 4'd9;
    localparam logic [3:0] S_TOP_WAIT = 4'd10;
    localparam logic [3:0] S_EMIT     = 4'd11;

    localparam logic [1:0] K_ON  = 2'd0;
    localparam logic [1:0] K_LEG = 2'd1;
    localparam logic [1:0] K_REL = 2'd2;

    localparam logic [VIDX_W-1:0] V_LAST = VIDX_W'(VOICES - 1);

    logic [3:0]         state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [1:0]         kind_reg, kind_next;
    logic [VIDX_W-1:0]  vidx_reg, vidx_next;
    logic [VIDX_W-1:0]  target_reg, target_next;
    logic               free_reg, free_next;
    logic [STAMP_W-1:0] oldest_reg, oldest_next;
    logic [STAMP_W-1:0] stamp_cnt_reg, stamp_cnt_next;
    logic [SCNT_W-1:0]  sidx_reg, sidx_next;
    logic [SCNT_W-1:0]  count_reg, count_next;
    logic [NOTE_W-1:0]  top_reg, top_next;

    logic [NOTE_W-1:0]  vnote_reg [VOICES];
    logic [NOTE_W-1:0]  vnote_next [VOICES];
    logic [NOTE_W-1:0]  vvel_reg [VOICES];
    logic [NOTE_W-1:0]  vvel_next [VOICES];
    logic [STAMP_W-1:0] vstamp_reg [VOICES];
    logic [STAMP_W-1:0] vstamp_next [VOICES];
    logic [VOICES-1:0]  vact_reg, vact_next;

    logic               ov_reg, ov_next;
    logic [VIDX_W-1:0]  ovoice_reg, ovoice_next;
    logic [NOTE_W-1:0]  onote_reg, onote_next;
    logic [NOTE_W-1:0]  ovel_reg, ovel_next;
    logic               ogate_reg, ogate_next;
    logic               orst_reg, orst_next;
    logic               olast_reg, olast_next;

    logic [NOTE_W-1:0]  stack_mem [STACK_DEPTH];
    logic [NOTE_W-1:0]  rd_data_reg;
    logic               rd_en, we;
    logic [SIDX_W-1:0]  rd_addr, wa;
    logic [NOTE_W-1:0]  wd;
    logic [SCNT_W-1:0]  sidx_inc;

    assign sidx_inc = SCNT_W'(sidx_reg + 1'b1);

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        kind_next      = kind_reg;
        vidx_next      = vidx_reg;
        target_next    = target_reg;
        free_next      = free_reg;
        oldest_next    = oldest_reg;
        stamp_cnt_next = stamp_cnt_reg;
        sidx_next      = sidx_reg;
        count_next     = count_reg;
        top_next       = top_reg;
        vnote_next     = vnote_reg;
        vvel_next      = vvel_reg;
        vstamp_next    = vstamp_reg;
        vact_next      = vact_reg;
        ov_next        = 1'b0;
        ovoice_next    = ovoice_reg;
        onote_next     = onote_reg;
        ovel_next      = ovel_reg;
        ogate_next     = ogate_reg;
        orst_next      = orst_reg;
        olast_next     = olast_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        we             = 1'b0;
        wa             = '0;
        wd             = cmd_reg.note;

        case (state_reg)
            S_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop         = 1'b1;
                    cmd_next    = fifo_cmd;
                    vidx_next   = '0;
                    sidx_next   = '0;
                    free_next   = 1'b0;
                    oldest_next = '1;
                    target_next = '0;
                    case (fifo_cmd.op)
                        OP_POLY_ON:  state_next = S_PSCAN;
                        OP_POLY_OFF: state_next = S_POFF;
                        OP_MONO_ON:  state_next = S_RM_RD;
                        OP_MONO_OFF: state_next = S_RM_RD;
                        OP_ALL_OFF:
                        begin
                            kind_next  = K_REL;
                            count_next = '0;
                            state_next = S_EMIT;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_PSCAN:
            begin
                // first free voice wins, else strictly oldest stamp
                if (!free_reg)
                begin
                    if (!vact_reg[vidx_reg])
                    begin
                        target_next = vidx_reg;
                        free_next   = 1'b1;
                    end
                    else if (vstamp_reg[vidx_reg] < oldest_reg)
                    begin
                        target_next = vidx_reg;
                        oldest_next = vstamp_reg[vidx_reg];
                    end
                end
                if (vidx_reg == V_LAST)
                begin
                    vidx_next  = target_next;
                    state_next = S_PON;
                end
                else
                    vidx_next = VIDX_W'(vidx_reg + 1'b1);
            end
            S_PON:
            begin
                stamp_cnt_next        = STAMP_W'(stamp_cnt_reg + 1'b1);
                vnote_next[vidx_reg]  = cmd_reg.note;
                vvel_next[vidx_reg]   = cmd_reg.vel;
                vact_next[vidx_reg]   = 1'b1;
                vstamp_next[vidx_reg] = stamp_cnt_next;
                ov_next     = 1'b1;
                ovoice_next = vidx_reg;
                onote_next  = cmd_reg.note;
                ovel_next   = cmd_reg.vel;
                ogate_next  = 1'b1;
                orst_next   = 1'b1;
                olast_next  = 1'b1;
                state_next  = S_IDLE;
            end
            S_POFF:
            begin
                if (vact_reg[vidx_reg] && vnote_reg[vidx_reg] == cmd_reg.note)
                begin
                    vact_next[vidx_reg]  = 1'b0;
                    vnote_next[vidx_reg] = '0;
                    vvel_next[vidx_reg]  = '0;
                    ov_next     = 1'b1;
                    ovoice_next = vidx_reg;
                    onote_next  = '0;
                    ovel_next   = '0;
                    ogate_next  = 1'b0;
                    orst_next   = 1'b0;
                    olast_next  = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (vidx_reg == V_LAST)
                    state_next = S_IDLE;
                else
                    vidx_next = VIDX_W'(vidx_reg + 1'b1);
            end
            S_RM_RD:
            begin
                if (sidx_reg >= count_reg)
                begin
                    vidx_next = '0;
                    if (cmd_reg.op == OP_MONO_ON)
                        state_next = S_PUSH;
                    else if (count_reg != '0)
                        state_next = S_TOP_RD;
                    else
                    begin
                        kind_next  = K_REL;
                        state_next = S_EMIT;
                    end
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = sidx_reg[SIDX_W-1:0];
                    state_next = S_RM_CMP;
                end
            end
            S_RM_CMP:
            begin
                if (rd_data_reg == cmd_reg.note)
                    state_next = S_SH_RD;
                else
                begin
                    sidx_next  = sidx_inc;
                    state_next = S_RM_RD;
                end
            end
            S_SH_RD:
            begin
                if (sidx_inc >= count_reg)
                begin
                    // close the gap: drop one entry and leave the scan
                    count_next = SCNT_W'(count_reg - 1'b1);
                    sidx_next  = count_reg;
                    state_next = S_RM_RD;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = sidx_inc[SIDX_W-1:0];
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                we         = 1'b1;
                wa         = sidx_reg[SIDX_W-1:0];
                wd         = rd_data_reg;
                sidx_next  = sidx_inc;
                state_next = S_SH_RD;
            end
            S_PUSH:
            begin
                if (count_reg < SCNT_W'(STACK_DEPTH))
                begin
                    we         = 1'b1;
                    wa         = count_reg[SIDX_W-1:0];
                    count_next = SCNT_W'(count_reg + 1'b1);
                end
                kind_next  = K_ON;
                state_next = S_EMIT;
            end
            S_TOP_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = SIDX_W'(count_reg - 1'b1);
                state_next = S_TOP_WAIT;
            end
            S_TOP_WAIT:
            begin
                top_next   = rd_data_reg;
                kind_next  = K_LEG;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                ov_next     = 1'b1;
                ovoice_next = vidx_reg;
                olast_next  = (vidx_reg == V_LAST);
                case (kind_reg)
                    K_ON:
                    begin
                        stamp_cnt_next        = STAMP_W'(stamp_cnt_reg + 1'b1);
                        vnote_next[vidx_reg]  = cmd_reg.note;
                        vvel_next[vidx_reg]   = cmd_reg.vel;
                        vact_next[vidx_reg]   = 1'b1;
                        vstamp_next[vidx_reg] = stamp_cnt_next;
                        onote_next = cmd_reg.note;
                        ovel_next  = cmd_reg.vel;
                        ogate_next = 1'b1;
                        orst_next  = 1'b1;
                    end
                    K_LEG:
                    begin
                        vnote_next[vidx_reg] = top_reg;
                        onote_next = vact_reg[vidx_reg] ? top_reg : '0;
                        ovel_next  = vact_reg[vidx_reg] ? vvel_reg[vidx_reg] : '0;
                        ogate_next = vact_reg[vidx_reg];
                        orst_next  = 1'b0;
                    end
                    default:
                    begin
                        vact_next[vidx_reg]  = 1'b0;
                        vnote_next[vidx_reg] = '0;
                        vvel_next[vidx_reg]  = '0;
                        onote_next = '0;
                        ovel_next  = '0;
                        ogate_next = 1'b0;
                        orst_next  = 1'b0;
                        count_next = '0;
                    end
                endcase
                if (vidx_reg == V_LAST)
                    state_next = S_IDLE;
                else
                    vidx_next = VIDX_W'(vidx_reg + 1'b1);
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            stack_mem[wa] <= wd;
        if (rd_en)
            rd_data_reg <= stack_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        kind_reg    <= kind_next;
        target_reg  <= target_next;
        oldest_reg  <= oldest_next;
        top_reg     <= top_next;
        ovoice_reg  <= ovoice_next;
        onote_reg   <= onote_next;
        ovel_reg    <= ovel_next;
        ogate_reg   <= ogate_next;
        orst_reg    <= orst_next;
        olast_reg   <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            vidx_reg      <= '0;
            free_reg      <= 1'b0;
            sidx_reg      <= '0;
            count_reg     <= '0;
            stamp_cnt_reg <= '0;
            vact_reg      <= '0;
            ov_reg        <= 1'b0;
            for (int i = 0; i < VOICES; i++)
            begin
                vnote_reg[i]  <= '0;
                vvel_reg[i]   <= '0;
                vstamp_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            vidx_reg      <= vidx_next;
            free_reg      <= free_next;
            sidx_reg      <= sidx_next;
            count_reg     <= count_next;
            stamp_cnt_reg <= stamp_cnt_next;
            vact_reg      <= vact_next;
            ov_reg        <= ov_next;
            vnote_reg     <= vnote_next;
            vvel_reg      <= vvel_next;
            vstamp_reg    <= vstamp_next;
        end
    end

    assign result_valid   = ov_reg;
    assign voice          = ovoice_reg;
    assign voice_note     = onote_reg;
    assign voice_velocity = ovel_reg;
    assign gate           = ogate_reg;
    assign restart        = orst_reg;
    assign last           = olast_reg;

    `SVA_ASSERT_IMP(a_count_max, 1'b1, count_reg <= SCNT_W'(STACK_DEPTH))
    `SVA_ASSERT_IMP(a_release_zero, ov_reg && !ogate_reg, onote_reg == '0 && ovel_reg == '0)
    `SVA_ASSERT_IMP(a_mid_event_busy, ov_reg && !olast_reg, state_reg == S_EMIT)
    `SVA_ASSERT_NXT(a_restart_gated, ov_next && orst_next, ogate_reg)
endmodule

// ----- src/synth_voice_allocator.sv -----
// Top level of the note-event voice allocator.
//
// Input channel: drive func, note and velocity with start; an event is taken
// at a rising edge where start is high and busy is low. busy rises only when
// the two-entry command queue is full. Unknown event kinds are dropped.
// Mode register: cfg_data is written when cfg_valid is high (cfg_ready is
// always high); write it only while no event is pending.
// Results: one beat per cycle marked by result_valid, last high on the final
// beat of an event. The receiver cannot stall: every beat is taken as shown.
// Per event: poly note on scans the voices and emits one beat, poly note
// off scans for the note and emits at most one beat, and all notes off emits
// one beat per voice. Mono events scan the note stack entry by entry and
// shift the entries above a match down, then emit one beat per voice.
// The front end keeps accepting while the back end works, up to the queue
// depth. Reset clears the voices, the stamps, the stack count, the queue and
// selects mono mode; stack entries are not cleared.
module synth_voice_allocator
    import sva_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        func,
    input  logic [NOTE_W-1:0] note,
    input  logic [NOTE_W-1:0] velocity,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              cfg_data,
    output logic              result_valid,
    output logic [VIDX_W-1:0] voice,
    output logic [NOTE_W-1:0] voice_note,
    output logic [NOTE_W-1:0] voice_velocity,
    output logic              gate,
    output logic              restart,
    output logic              last
);
    // command queue hookup between front and back
    logic fifo_full, fifo_empty, push, pop;
    cmd_t push_cmd, pop_cmd;

    sva_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .func      (func),
        .note      (note),
        .velocity  (velocity),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .fifo_full (fifo_full),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .push      (push),
        .cmd       (push_cmd)
    );

    sva_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .full     (fifo_full),
        .empty    (fifo_empty)
    );

    // back end owns voice state and the note stack
    sva_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .fifo_empty     (fifo_empty),
        .fifo_cmd       (pop_cmd),
        .pop            (pop),
        .result_valid   (result_valid),
        .voice          (voice),
        .voice_note     (voice_note),
        .voice_velocity (voice_velocity),
        .gate           (gate),
        .restart        (restart),
        .last           (last)
    );
endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the note-event voice allocator.
module tb_top
    import sva_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] FUNC_BAD = 2'd3;
    localparam int TIMEOUT_NS = 20_000_000;
    // Drain margin sized to cover the longest mono event.
    localparam int DRAIN_CYCLES = 4 * STACK_DEPTH + 2 * VOICES + 16;

    typedef struct packed {
        logic [VIDX_W-1:0] voice;
        logic [NOTE_W-1:0] note;
        logic [NOTE_W-1:0] vel;
        logic              gate;
        logic              restart;
        logic              last;
    } voice_beat_t;

    typedef struct {
        logic [1:0]        func;
        logic [NOTE_W-1:0] note;
        logic [NOTE_W-1:0] vel;
        bit                has_known;  // typed-in expectation for the first beat
        voice_beat_t       known;
    } event_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [1:0] func = FUNC_ON;
    logic [NOTE_W-1:0] note = '0;
    logic [NOTE_W-1:0] velocity = '0;
    logic cfg_valid = 1'b0;
    logic cfg_data = 1'b0;
    logic busy, cfg_ready, result_valid, gate, restart, last;
    logic [VIDX_W-1:0] voice;
    logic [NOTE_W-1:0] voice_note, voice_velocity;

    synth_voice_allocator u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .func(func), .note(note), .velocity(velocity),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .result_valid(result_valid), .voice(voice), .voice_note(voice_note),
        .voice_velocity(voice_velocity), .gate(gate), .restart(restart),
        .last(last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the allocator state.
    bit                poly;
    logic [NOTE_W-1:0] v_note [VOICES];
    logic [NOTE_W-1:0] v_vel [VOICES];
    bit                v_on [VOICES];
    logic [31:0]       v_stamp [VOICES];
    logic [31:0]       stamp_ctr;
    logic [NOTE_W-1:0] key_stack [$];

    voice_beat_t pending_beats [$];
    voice_beat_t known_beats [$];  // typed-in expectations, checked on top
    int  errors = 0;
    int  sender_gap_pct = 0;
    bit  done = 0;

    function automatic voice_beat_t voice_beat(int v, bit rs);
        voice_beat_t b;
        b.voice   = VIDX_W'(v);
        b.note    = v_on[v] ? v_note[v] : '0;
        b.vel     = v_on[v] ? v_vel[v] : '0;
        b.gate    = v_on[v];
        b.restart = rs;
        b.last    = 1'b0;
        return b;
    endfunction

    function automatic void drop_key(logic [NOTE_W-1:0] n);
        foreach (key_stack[i])
        begin
            if (key_stack[i] == n)
            begin
                key_stack.delete(i);
                return;
            end
        end
    endfunction

    function automatic void release_voices(ref voice_beat_t q[$]);
        for (int i = 0; i < VOICES; i++)
        begin
            v_on[i] = 0;
            v_note[i] = '0;
            v_vel[i] = '0;
            q.push_back(voice_beat(i, 0));
        end
        key_stack.delete();
    endfunction

    // Advance the shadow state by one event and queue the beats it causes.
    function automatic void allocate_event(logic [1:0] f, logic [NOTE_W-1:0] n,
                                           logic [NOTE_W-1:0] vel);
        voice_beat_t q [$];
        int tgt;
        logic [31:0] oldest;
        if (f == FUNC_ALL)
            release_voices(q);
        else if (f == FUNC_ON && poly)
        begin
            tgt = 0;
            oldest = 32'hFFFF_FFFF;
            for (int i = 0; i < VOICES; i++)
            begin
                if (!v_on[i])
                begin
                    tgt = i;
                    break;
                end
                if (v_stamp[i] < oldest)
                begin
                    oldest = v_stamp[i];
                    tgt = i;
                end
            end
            v_note[tgt] = n;
            v_vel[tgt] = vel;
            v_on[tgt] = 1;
            stamp_ctr++;
            v_stamp[tgt] = stamp_ctr;
            q.push_back(voice_beat(tgt, 1));
        end
        else if (f == FUNC_ON)
        begin
            drop_key(n);
            if (key_stack.size() < STACK_DEPTH)
                key_stack.push_back(n);
            for (int i = 0; i < VOICES; i++)
            begin
                v_note[i] = n;
                v_vel[i] = vel;
                v_on[i] = 1;
                stamp_ctr++;
                v_stamp[i] = stamp_ctr;
                q.push_back(voice_beat(i, 1));
            end
        end
        else if (f == FUNC_OFF && poly)
        begin
            for (int i = 0; i < VOICES; i++)
            begin
                if (v_on[i] && v_note[i] == n)
                begin
                    v_on[i] = 0;
                    v_note[i] = '0;
                    v_vel[i] = '0;
                    q.push_back(voice_beat(i, 0));
                    break;
                end
            end
        end
        else if (f == FUNC_OFF)
        begin
            drop_key(n);
            if (key_stack.size() > 0)
            begin
                // Fall back legato to the newest key still held.
                for (int i = 0; i < VOICES; i++)
                begin
                    v_note[i] = key_stack[$];
                    q.push_back(voice_beat(i, 0));
                end
            end
            else
                release_voices(q);
        end
        if (q.size() > 0)
            q[$].last = 1'b1;
        foreach (q[i])
            pending_beats.push_back(q[i]);
    endfunction

    // Compare every beat with the oldest expectation; it is never held off.
    always @(posedge clk)
    begin
        voice_beat_t got, exp_b;
        if (rst_n && result_valid)
        begin
            got = '{voice, voice_note, voice_velocity, gate, restart, last};
            if (pending_beats.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected beat %p", got);
            end
            else
            begin
                exp_b = pending_beats.pop_front();
                if (known_beats.size() > 0 && known_beats[0] == exp_b)
                    void'(known_beats.pop_front());
                if (got !== exp_b)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("beat mismatch: expected %p got %p", exp_b, got);
                end
            end
        end
    end

    task automatic idle_until_drained();
        start <= 1'b0;
        while (pending_beats.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the mode register; only called while the block is idle.
    task automatic write_mode(bit m);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        poly = m;
    endtask

    // Present one event and hold it until the block takes it; a random gap before
    // the next event or an idle phase drops start.
    task automatic send_event(logic [1:0] f, logic [NOTE_W-1:0] n,
                              logic [NOTE_W-1:0] vel);
        while (sender_gap_pct > 0 && $urandom_range(99) < sender_gap_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        func <= f;
        note <= n;
        velocity <= vel;
        do
            @(posedge clk);
        while (busy);
        allocate_event(f, n, vel);
    endtask

    // Random content: notes come from a narrow window so offs hit held keys.
    task automatic random_events(int count, int base);
        int r;
        logic [NOTE_W-1:0] n;
        for (int k = 0; k < count; k++)
        begin
            r = $urandom_range(99);
            n = (r < 90) ? NOTE_W'(base + $urandom_range(19)) : NOTE_W'($urandom);
            if (r < 50)
                send_event(FUNC_ON, n, NOTE_W'($urandom));
            else if (r < 88)
                send_event(FUNC_OFF, n, NOTE_W'($urandom));
            else if (r < 95)
                send_event(FUNC_ALL, NOTE_W'($urandom), NOTE_W'($urandom));
            else
                send_event(FUNC_BAD, NOTE_W'($urandom), NOTE_W'($urandom));
        end
    endtask

    task automatic run_table(const ref event_row_t rows[$]);
        foreach (rows[i])
        begin
            if (rows[i].has_known)
                known_beats.push_back(rows[i].known);
            send_event(rows[i].func, rows[i].note, rows[i].vel);
        end
        idle_until_drained();
    endtask

    initial
    begin
        event_row_t mono_rows [$];
        event_row_t poly_rows [$];
        poly = 0;
        stamp_ctr = '0;
        for (int i = 0; i < VOICES; i++)
        begin
            v_note[i] = '0;
            v_vel[i] = '0;
            v_on[i] = 0;
            v_stamp[i] = '0;
        end

        // Mono: extremes, stack overflow, legato fallback, empty-stack release.
        mono_rows.push_back('{FUNC_ON, 7'd127, 7'd127, 1, '{2'd0, 7'd127, 7'd127, 1, 1, 0}});
        mono_rows.push_back('{FUNC_ON, 7'd0, 7'd0, 1, '{2'd0, 7'd0, 7'd0, 1, 1, 0}});
        mono_rows.push_back('{FUNC_OFF, 7'd0, 7'd55, 0, '0});
        mono_rows.push_back('{FUNC_OFF, 7'd127, 7'd0, 1, '{2'd0, 7'd0, 7'd0, 0, 0, 0}});
        mono_rows.push_back('{FUNC_BAD, 7'd127, 7'd127, 0, '0});
        for (int i = 0; i < 17; i++)
            mono_rows.push_back('{FUNC_ON, NOTE_W'(40 + i), NOTE_W'(3 * i + 1), 0, '0});
        mono_rows.push_back('{FUNC_OFF, 7'd99, 7'd0, 0, '0});
        mono_rows.push_back('{FUNC_OFF, 7'd55, 7'd0, 0, '0});
        mono_rows.push_back('{FUNC_ALL, 7'd0, 7'd0, 1, '{2'd0, 7'd0, 7'd0, 0, 0, 0}});

        // Poly: fill, steal oldest, off for missing and held notes.
        poly_rows.push_back('{FUNC_ON, 7'd60, 7'd100, 1, '{2'd0, 7'd60, 7'd100, 1, 1, 1}});
        poly_rows.push_back('{FUNC_ON, 7'd64, 7'd90, 0, '0});
        poly_rows.push_back('{FUNC_ON, 7'd67, 7'd80, 0, '0});
        poly_rows.push_back('{FUNC_ON, 7'd72, 7'd70, 0, '0});
        poly_rows.push_back('{FUNC_OFF, 7'd5, 7'd0, 0, '0});
        poly_rows.push_back('{FUNC_OFF, 7'd64, 7'd0, 0, '0});
        poly_rows.push_back('{FUNC_ON, 7'd72, 7'd0, 0, '0});
        poly_rows.push_back('{FUNC_OFF, 7'd72, 7'd0, 0, '0});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_table(mono_rows);
        write_mode(1);
        run_table(poly_rows);
        write_mode(0);

        // Random phases alternate the mode and the sender's gap rate.
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: sender_gap_pct = 0;
                1: sender_gap_pct = 80;
                2: sender_gap_pct = 12;
                default: sender_gap_pct = 40;
            endcase
            random_events(28, 30 + 10 * ph);
            // Pause the sender until the block has drained.
            idle_until_drained();
            random_events(28, 30 + 10 * ph);
            idle_until_drained();
            write_mode((ph % 2) == 0);
        end

        idle_until_drained();
        if (known_beats.size() > 0)
        begin
            errors++;
            $display("%0d typed-in expectations not met", known_beats.size());
        end
        if (pending_beats.size() > 0)
            errors++;
        done = 1;
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        if (!done)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end
endmodule

// ----- synth_voice_allocator.f -----
+incdir+src
src/sva_pkg.sv
src/sva_front.sv
src/sva_fifo.sv
src/sva_back.sv
src/synth_voice_allocator.sv
tb/tb_top.sv
